// ===== rtl/core/lrs_pkg.sv =====
// Shared types and constants for the streaming Life row engine.
package lrs_pkg;

   // Fixed field widths of the request and result payloads.
   localparam int ROW_BITS = 64;
   localparam int CSR_BITS = 7;

   // Row width after reset: every column in use.
   localparam logic [CSR_BITS-1:0] ROW_WIDTH_RESET = 7'd64;

   // B3/S23 rule: birth on three neighbours, survival on two or three.
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Result queue geometry.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // Number of results one request may push.
   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic [ROW_BITS-1:0] row_bits;
      logic                last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] next_row;
      logic                frame_end;
      logic                run_end;
   } rsp_type;

   // The three vertically stacked bits one column shows to its neighbours.
   typedef struct packed {
      logic upper;
      logic middle;
      logic lower;
   } cell_bits_type;

endpackage

// ===== rtl/core/lrs_cell.sv =====
// One column of the Life row engine: holds two rows' bits and applies the rule.
module lrs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  last_row,
   input  logic                  col_en,
   input  logic                  row_bit,
   input  lrs_pkg::cell_bits_type left_bits,
   input  lrs_pkg::cell_bits_type right_bits,
   output lrs_pkg::cell_bits_type own_bits,
   output logic                  held_bit,
   output logic                  bottom_bit
);

   logic       upper_ff, upper_in;
   logic       middle_ff, middle_in;
   logic       lower_bit;
   logic [3:0] held_cnt;
   logic [3:0] bottom_cnt;

   // Incoming bit is dead when its column is out of use.
   assign lower_bit = row_bit & col_en;

   assign own_bits.upper  = upper_ff;
   assign own_bits.middle = middle_ff;
   assign own_bits.lower  = lower_bit;

   // Neighbour count for the held row: above, beside and below.
   assign held_cnt = 4'(left_bits.upper)  + 4'(upper_ff)  + 4'(right_bits.upper)
                   + 4'(left_bits.middle) + 4'(right_bits.middle)
                   + 4'(left_bits.lower)  + 4'(lower_bit) + 4'(right_bits.lower);

   // Neighbour count for the incoming row as the bottom row of its frame.
   assign bottom_cnt = 4'(left_bits.middle) + 4'(middle_ff) + 4'(right_bits.middle)
                     + 4'(left_bits.lower)  + 4'(right_bits.lower);

   assign held_bit   = col_en & ((held_cnt == lrs_pkg::BIRTH_COUNT) |
                                 (middle_ff & (held_cnt == lrs_pkg::SURVIVE_COUNT)));
   assign bottom_bit = col_en & ((bottom_cnt == lrs_pkg::BIRTH_COUNT) |
                                 (lower_bit & (bottom_cnt == lrs_pkg::SURVIVE_COUNT)));

   // Rows shift down on each request; the frame's last row clears both.
   always_comb begin
      upper_in  = upper_ff;
      middle_in = middle_ff;
      if (accept) begin
         if (last_row) begin
            upper_in  = 1'b0;
            middle_in = 1'b0;
         end else begin
            upper_in  = middle_ff;
            middle_in = lower_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
      end
   end

endmodule

// ===== rtl/core/lrs_rsp_queue.sv =====
// Small result queue: takes up to two results a cycle, gives one unless stalled.
module lrs_rsp_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [1:0]                            push_cnt,
   input  lrs_pkg::rsp_type                      push_first,
   input  lrs_pkg::rsp_type                      push_second,
   output logic [lrs_pkg::QUEUE_CNT_BITS-1:0]    fill,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lrs_pkg::rsp_type                      rsp_data
);

   lrs_pkg::rsp_type                         entry_ff [lrs_pkg::QUEUE_DEPTH];
   logic [lrs_pkg::QUEUE_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [lrs_pkg::QUEUE_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [lrs_pkg::QUEUE_CNT_BITS-1:0]       fill_ff, fill_in;
   logic [lrs_pkg::QUEUE_PTR_BITS-1:0]       wr_next;
   logic                                     pop;

   assign fill      = fill_ff;
   assign rsp_valid = (fill_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   assign wr_next   = wr_ptr_ff + 1'b1;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + lrs_pkg::QUEUE_PTR_BITS'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + lrs_pkg::QUEUE_CNT_BITS'(push_cnt)
                - lrs_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage: the first result at the write pointer, the second after it.
   always_ff @(posedge clock) begin
      if (push_cnt != lrs_pkg::PUSH_NONE) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_cnt == lrs_pkg::PUSH_TWO) begin
         entry_ff[wr_next] <= push_second;
      end
   end

endmodule

// ===== rtl/core/life_row_stream_step_core.sv =====
// Top level of the streaming Life (B3/S23) row engine.
//
//   channel   direction  payload                          handshake
//   req_      in         row_bits, last_row               req_valid / req_stall
//   rsp_      out        next_row, frame_end, run_end     rsp_valid / rsp_stall
//   csr_      in         row_width                        csr_wr_en
//
// One request is taken per unstalled cycle; its results are queued in registers.
// A bottom row after a held row yields two results, so short frames run at the
// output rate of one result per unstalled cycle, set by the single queue read port.
// Requests stall while the four-entry result queue has fewer than two free places.
// Synchronous active-high reset clears the held rows, the queue and row_width to 64.
module life_row_stream_step_core #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lrs_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lrs_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [lrs_pkg::CSR_BITS-1:0]  csr_wr_data
);

   logic [lrs_pkg::CSR_BITS-1:0]        row_width_ff, row_width_in;
   logic                                pending_ff, pending_in;
   logic                                accept;
   logic [lrs_pkg::ROW_BITS-1:0]        held_vec;
   logic [lrs_pkg::ROW_BITS-1:0]        bottom_vec;
   lrs_pkg::cell_bits_type              col_bits [MAX_WIDTH+2];
   logic [1:0]                          push_cnt;
   lrs_pkg::rsp_type                    push_first;
   lrs_pkg::rsp_type                    push_second;
   lrs_pkg::rsp_type                    held_rsp;
   lrs_pkg::rsp_type                    bottom_rsp;
   logic [lrs_pkg::QUEUE_CNT_BITS-1:0]  fill;

   // Request is taken when the queue can absorb two results.
   assign req_stall = (fill > lrs_pkg::QUEUE_CNT_BITS'(lrs_pkg::QUEUE_DEPTH - 2));
   assign accept    = req_valid & ~req_stall;

   // Width register and row-held flag.
   always_comb begin
      row_width_in = csr_wr_en ? csr_wr_data : row_width_ff;
      pending_in   = accept ? ~req_data.last_row : pending_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= lrs_pkg::ROW_WIDTH_RESET;
         pending_ff   <= 1'b0;
      end else begin
         row_width_ff <= row_width_in;
         pending_ff   <= pending_in;
      end
   end

   // Dead columns beyond both edges of the grid.
   assign col_bits[0]           = '0;
   assign col_bits[MAX_WIDTH+1] = '0;

   // Row of column cells; each sees its left and right neighbours.
   for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col
      lrs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .last_row   (req_data.last_row),
         .col_en     (row_width_ff > lrs_pkg::CSR_BITS'(i)),
         .row_bit    (req_data.row_bits[i]),
         .left_bits  (col_bits[i]),
         .right_bits (col_bits[i+2]),
         .own_bits   (col_bits[i+1]),
         .held_bit   (held_vec[i]),
         .bottom_bit (bottom_vec[i])
      );
   end

   // Columns above the built width are always dead.
   for (genvar j = MAX_WIDTH; j < lrs_pkg::ROW_BITS; j++) begin : g_dead
      assign held_vec[j]   = 1'b0;
      assign bottom_vec[j] = 1'b0;
   end

   // Results of one request: the held row if any, then the bottom row on a frame end.
   always_comb begin
      held_rsp.next_row    = held_vec;
      held_rsp.frame_end   = 1'b0;
      held_rsp.run_end     = ~req_data.last_row;
      bottom_rsp.next_row  = bottom_vec;
      bottom_rsp.frame_end = 1'b1;
      bottom_rsp.run_end   = 1'b1;
      push_first           = held_rsp;
      push_second          = bottom_rsp;
      push_cnt             = lrs_pkg::PUSH_NONE;
      if (accept) begin
         if (pending_ff && req_data.last_row) begin
            push_cnt = lrs_pkg::PUSH_TWO;
         end else if (pending_ff) begin
            push_cnt = lrs_pkg::PUSH_ONE;
         end else if (req_data.last_row) begin
            push_cnt   = lrs_pkg::PUSH_ONE;
            push_first = bottom_rsp;
         end
      end
   end

   lrs_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_cnt    (push_cnt),
      .push_first  (push_first),
      .push_second (push_second),
      .fill        (fill),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // A frame's bottom row leaves no row held.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_row |=> !pending_ff)
      else $error("row still held after the frame's bottom row");

   // Any request that completes a row must leave a result waiting.
   assert property (@(posedge clock) disable iff (reset)
      accept && (pending_ff || req_data.last_row) |=> rsp_valid)
      else $error("request produced no result");

   // Requests are held back only while results are queued.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with an empty result queue");

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      fill <= lrs_pkg::QUEUE_CNT_BITS'(lrs_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

endmodule

// ===== bench/tb_life_row_stream_step_core.sv =====
// Self-checking testbench for the streaming Life row engine.
`timescale 1ns / 100ps

module tb_life_row_stream_step_core;

   localparam int ENGINE_WIDTH = 64;
   localparam int ROW_TARGET   = 1550;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int SETTLE_WAIT  = 6;
   localparam int TAIL_WAIT    = 20;
   localparam int PLAN_SIZE    = 26;

   // One row of the directed plan, with an optional width write before it.
   typedef struct packed {
      logic        wr;
      logic [6:0]  width;
      logic [63:0] row;
      logic        last;
      logic        fixed;
      logic [63:0] fixed_row;
   } plan_step_type;

   logic                              clock;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   lrs_pkg::req_type                  req_data    = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   lrs_pkg::rsp_type                  rsp_data;
   logic                              csr_wr_en   = 1'b0;
   logic [lrs_pkg::CSR_BITS-1:0]      csr_wr_data = '0;

   // Reference copy of the engine state and its width register.
   logic [6:0]  life_width = lrs_pkg::ROW_WIDTH_RESET;
   logic [63:0] life_upper = '0;
   logic [63:0] life_middle = '0;
   logic        life_pending = 1'b0;

   lrs_pkg::rsp_type expected_rows[$];
   plan_step_type    plan [PLAN_SIZE];

   int  fault_count = 0;
   int  cycle_count = 0;
   int  rows_sent = 0;
   int  stall_left = 0;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;

   life_row_stream_step_core #(
      .MAX_WIDTH (ENGINE_WIDTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock with a 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Columns in use for a given width; widths above the engine's limit act as the limit.
   function automatic logic [63:0] live_mask(input logic [6:0] w);
      int eff;
      eff = (w > ENGINE_WIDTH) ? ENGINE_WIDTH : int'(w);
      if (eff >= 64) return '1;
      return (64'd1 << eff) - 64'd1;
   endfunction

   // Next generation of the middle row from its two vertical neighbours.
   function automatic logic [63:0] life_next_row(input logic [63:0] above,
                                                 input logic [63:0] here,
                                                 input logic [63:0] below,
                                                 input logic [6:0]  w);
      logic [63:0] nb [8];
      logic [63:0] res;
      int          cnt;
      nb[0] = above << 1;
      nb[1] = above;
      nb[2] = above >> 1;
      nb[3] = here << 1;
      nb[4] = here >> 1;
      nb[5] = below << 1;
      nb[6] = below;
      nb[7] = below >> 1;
      res = '0;
      for (int col = 0; col < 64; col++) begin
         cnt = 0;
         for (int k = 0; k < 8; k++) cnt += int'(nb[k][col]);
         if (cnt == int'(lrs_pkg::BIRTH_COUNT) ||
             (here[col] && cnt == int'(lrs_pkg::SURVIVE_COUNT))) begin
            res[col] = 1'b1;
         end
      end
      return res & live_mask(w);
   endfunction

   // Gap length: mostly none or short, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Works out the results one accepted request causes and advances the held rows.
   task automatic predict_row(input logic [63:0] raw, input logic last);
      logic [63:0] row;
      row = raw & live_mask(life_width);
      if (life_pending) begin
         expected_rows.push_back('{next_row: life_next_row(life_upper, life_middle, row,
                                                          life_width),
                                   frame_end: 1'b0, run_end: !last});
         if (last) begin
            expected_rows.push_back('{next_row: life_next_row(life_middle, row, '0,
                                                             life_width),
                                      frame_end: 1'b1, run_end: 1'b1});
            life_upper   = '0;
            life_middle  = '0;
            life_pending = 1'b0;
         end else begin
            life_upper  = life_middle;
            life_middle = row;
         end
      end else if (last) begin
         expected_rows.push_back('{next_row: life_next_row('0, row, '0, life_width),
                                   frame_end: 1'b1, run_end: 1'b1});
         life_upper  = '0;
         life_middle = '0;
      end else begin
         life_upper   = '0;
         life_middle  = row;
         life_pending = 1'b1;
      end
   endtask

   // Offers one request after a random gap and holds it until it is taken.
   // A fixed row is a one-row frame whose single result is known beforehand.
   task automatic send_row(input logic [63:0] row, input logic last,
                           input logic fixed, input logic [63:0] fixed_row);
      int gap;
      @(negedge clock);
      gap = req_calm ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{row_bits: row, last_row: last};
      do @(posedge clock); while (req_stall);
      if (fixed) begin
         expected_rows.push_back('{next_row: fixed_row, frame_end: 1'b1, run_end: 1'b1});
         life_upper   = '0;
         life_middle  = '0;
         life_pending = 1'b0;
      end else begin
         predict_row(row, last);
      end
      rows_sent++;
   endtask

   // Stops sending and waits for every outstanding result.
   task automatic settle_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
   endtask

   // Writes row_width once the engine is quiet; a held row may still be pending.
   task automatic set_row_width(input logic [6:0] w);
      settle_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      life_width = w;
   endtask

   // Random row contents over a spread of densities.
   function automatic logic [63:0] random_row();
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1:    return a & b & c;
         2:       return a | b;
         3:       return '0;
         4:       return '1;
         5:       return (64'h7 << $urandom_range(0, 61)) | (a & b & c & b);
         default: return a;
      endcase
   endfunction

   // Result side back-pressure: random stall runs, never back to back.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!rsp_calm && $urandom_range(0, 99) < 25) stall_left = gap_length();
      end
   end

   // Each accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      lrs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rows.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: next_row %h frame_end %b run_end %b",
                        rsp_data.next_row, rsp_data.frame_end, rsp_data.run_end);
         end else begin
            want = expected_rows.pop_front();
            if (rsp_data.next_row !== want.next_row ||
                rsp_data.frame_end !== want.frame_end ||
                rsp_data.run_end !== want.run_end) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("result wrong: next_row %h/%h frame_end %b/%b run_end %b/%b",
                           want.next_row, rsp_data.next_row, want.frame_end,
                           rsp_data.frame_end, want.run_end, rsp_data.run_end);
            end
         end
      end
   end

   // Guard against a hung engine.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("life_row_stream_step_core: mismatch");
         $finish;
      end
   end

   // Directed plan, then random phases, then the final verdict.
   initial begin
      logic [6:0] w;
      int         frame_left;
      int         phase_rows;
      int         pick;

      plan = '{
         // Reset width, one-row frames: empty, full row, three in a line, edge pairs.
         '{1'b0, 7'd0,   64'h0,                  1'b1, 1'b1, 64'h0},
         '{1'b0, 7'd0,   '1,                     1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
         '{1'b0, 7'd0,   64'h7,                  1'b1, 1'b1, 64'h2},
         '{1'b0, 7'd0,   64'hC000_0000_0000_0003, 1'b1, 1'b1, 64'h0},
         // Vertical blinker, a block on the low edge and one on the high edge.
         '{1'b0, 7'd0,   64'h10,                 1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   64'h10,                 1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   64'h10,                 1'b1, 1'b0, 64'h0},
         '{1'b0, 7'd0,   64'h3,                  1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   64'h3,                  1'b1, 1'b0, 64'h0},
         '{1'b0, 7'd0,   64'hC000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   64'hC000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   64'h0,                  1'b1, 1'b0, 64'h0},
         // A full frame of live cells.
         '{1'b0, 7'd0,   '1,                     1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   '1,                     1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   '1,                     1'b1, 1'b0, 64'h0},
         // Zero width leaves every cell dead.
         '{1'b1, 7'd0,   '1,                     1'b1, 1'b1, 64'h0},
         '{1'b0, 7'd0,   '1,                     1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   '1,                     1'b1, 1'b0, 64'h0},
         // Width above the limit, then the narrowest widths.
         '{1'b1, 7'd127, '1,                     1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
         '{1'b1, 7'd1,   '1,                     1'b1, 1'b1, 64'h0},
         '{1'b1, 7'd5,   '1,                     1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   64'h15,                 1'b0, 1'b0, 64'h0},
         '{1'b0, 7'd0,   '1,                     1'b1, 1'b0, 64'h0},
         // Width narrowed while a row is held.
         '{1'b1, 7'd64,  64'hFFFF,               1'b0, 1'b0, 64'h0},
         '{1'b1, 7'd8,   64'hFFFF,               1'b1, 1'b0, 64'h0},
         '{1'b1, 7'd63,  '1,                     1'b1, 1'b1, 64'h3FFF_FFFF_FFFF_FFFE}
      };

      // Hold synchronous reset, then release it.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].wr) set_row_width(plan[i].width);
         send_row(plan[i].row, plan[i].last, plan[i].fixed, plan[i].fixed_row);
      end

      // Random phases; each starts with a width write after the results drain.
      frame_left = 0;
      while (rows_sent < ROW_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick < 6)        w = 7'd64;
         else if (pick == 6)  w = 7'($urandom_range(65, 127));
         else if (pick == 7)  w = 7'd0;
         else if (pick == 8)  w = 7'($urandom_range(1, 3));
         else                 w = 7'($urandom_range(1, 64));
         set_row_width(w);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         phase_rows = $urandom_range(30, 90);
         repeat (phase_rows) begin
            if (frame_left == 0)
               frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                       : $urandom_range(1, 6);
            frame_left--;
            send_row(random_row(), frame_left == 0, 1'b0, 64'h0);
         end
      end

      settle_results();
      repeat (TAIL_WAIT) @(posedge clock);
      if (fault_count == 0 && expected_rows.size() == 0) begin
         $display("life_row_stream_step_core: match");
      end else begin
         $display("life_row_stream_step_core: mismatch");
      end
      $finish;
   end

endmodule
